// ----- hdl/ascii_sentence_framer_xor_check_assert.svh -----
// Assertion macros shared by the framer RTL.
// Each use takes a label, the clock, the active-low reset, an antecedent,
// a consequent and a message.
`ifndef ASCII_SENTENCE_FRAMER_XOR_CHECK_ASSERT_SVH
`define ASCII_SENTENCE_FRAMER_XOR_CHECK_ASSERT_SVH

// Same-cycle implication.
`define ASFX_ASSERT_IMP(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define ASFX_ASSERT_NXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- hdl/asfx_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package asfx_pkg;

    localparam int unsigned BYTE_W = 8;
    localparam int unsigned POS_W  = 7;

    localparam logic [BYTE_W-1:0] START_BYTE = 8'h2A;
    localparam logic [BYTE_W-1:0] END_BYTE   = 8'h0D;

    // Last position a non-CR byte may take before the frame is dropped.
    localparam logic [POS_W-1:0] MAX_INDEX = 7'd90;
    // Shortest frame that can carry a checksum.
    localparam logic [POS_W-1:0] MIN_CHECKED_LENGTH = 7'd7;

    localparam logic [BYTE_W-1:0] CHAR_DIGIT_LO = 8'h30;
    localparam logic [BYTE_W-1:0] CHAR_DIGIT_HI = 8'h39;
    localparam logic [BYTE_W-1:0] CHAR_UPPER_LO = 8'h41;
    localparam logic [BYTE_W-1:0] CHAR_UPPER_HI = 8'h46;
    localparam logic [BYTE_W-1:0] CHAR_LOWER_LO = 8'h61;
    localparam logic [BYTE_W-1:0] CHAR_LOWER_HI = 8'h66;
    // Offsets that map 'A' and 'a' onto 10.
    localparam logic [BYTE_W-1:0] UPPER_OFFSET = 8'h37;
    localparam logic [BYTE_W-1:0] LOWER_OFFSET = 8'h57;

    typedef struct packed {
        logic       valid;
        logic [3:0] value;
    } hex_digit_t;

    typedef struct packed {
        logic [POS_W-1:0]  frame_length;
        logic [BYTE_W-1:0] computed_xor;
        logic [BYTE_W-1:0] received_checksum;
        logic              hex_valid;
        logic              checksum_ok;
    } asfx_result_t;

    function automatic hex_digit_t hex_decode(input logic [BYTE_W-1:0] c);
        hex_digit_t d;
        d.valid = 1'b1;
        d.value = '0;
        if (c >= CHAR_DIGIT_LO && c <= CHAR_DIGIT_HI) begin
            d.value = 4'(c - CHAR_DIGIT_LO);
        end else if (c >= CHAR_UPPER_LO && c <= CHAR_UPPER_HI) begin
            d.value = 4'(c - UPPER_OFFSET);
        end else if (c >= CHAR_LOWER_LO && c <= CHAR_LOWER_HI) begin
            d.value = 4'(c - LOWER_OFFSET);
        end else begin
            d.valid = 1'b0;
        end
        return d;
    endfunction

endpackage

`default_nettype wire

// ----- hdl/asfx_frame_core.sv -----
`timescale 1ns / 1ps
`default_nettype none
`include "ascii_sentence_framer_xor_check_assert.svh"

module asfx_frame_core #(
    parameter logic [asfx_pkg::POS_W-1:0] MAX_INDEX = asfx_pkg::MAX_INDEX
) (
    input  wire logic                       aclk,
    input  wire logic                       aresetn,
    input  wire logic                       step,
    input  wire logic [asfx_pkg::BYTE_W-1:0] rx_byte,
    output logic                            emit,
    output asfx_pkg::asfx_result_t          result
);

    logic                         in_frame_reg, in_frame_next;
    logic [asfx_pkg::POS_W-1:0]   pos_reg, pos_next;
    logic [asfx_pkg::BYTE_W-1:0]  running_xor_reg, running_xor_next;
    logic [asfx_pkg::BYTE_W-1:0]  recent_reg [4];
    logic [asfx_pkg::BYTE_W-1:0]  recent_next [4];

    logic [asfx_pkg::POS_W-1:0]   pos_inc;
    logic [asfx_pkg::BYTE_W-1:0]  cx;
    logic [asfx_pkg::BYTE_W-1:0]  rc;
    asfx_pkg::hex_digit_t         d1, d2;

    assign emit    = in_frame_reg && (rx_byte == asfx_pkg::END_BYTE);
    assign pos_inc = pos_reg + 7'd1;

    // Result of closing the frame with the current byte.
    always_comb begin
        cx = running_xor_reg ^ recent_reg[3];
        d1 = asfx_pkg::hex_decode(recent_reg[1]);
        d2 = asfx_pkg::hex_decode(recent_reg[0]);
        rc = '0;
        if (d1.valid) begin
            rc = d2.valid ? {d1.value, d2.value} : {4'd0, d1.value};
        end
        result.frame_length      = pos_inc;
        result.computed_xor      = cx;
        result.received_checksum = rc;
        result.hex_valid         = d1.valid;
        result.checksum_ok       = (pos_inc >= asfx_pkg::MIN_CHECKED_LENGTH) && d1.valid
                                   && (rc == cx);
    end

    always_comb begin
        in_frame_next    = in_frame_reg;
        pos_next         = pos_reg;
        running_xor_next = running_xor_reg;
        for (int i = 0; i < 4; i++) begin
            recent_next[i] = recent_reg[i];
        end
        if (step) begin
            if (!in_frame_reg) begin
                if (rx_byte == asfx_pkg::START_BYTE) begin
                    // Open a frame; the start byte itself is held as zero.
                    in_frame_next    = 1'b1;
                    pos_next         = 7'd1;
                    running_xor_next = '0;
                    for (int i = 0; i < 4; i++) begin
                        recent_next[i] = '0;
                    end
                end
            end else if (emit) begin
                in_frame_next = 1'b0;
                pos_next      = pos_inc;
            end else begin
                // Shift the window; the oldest byte folds into the XOR.
                running_xor_next = running_xor_reg ^ recent_reg[3];
                recent_next[3]   = recent_reg[2];
                recent_next[2]   = recent_reg[1];
                recent_next[1]   = recent_reg[0];
                recent_next[0]   = rx_byte;
                pos_next         = pos_inc;
                if (pos_inc > MAX_INDEX) begin
                    in_frame_next = 1'b0;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_frame_reg    <= 1'b0;
            pos_reg         <= '0;
            running_xor_reg <= '0;
            for (int i = 0; i < 4; i++) begin
                recent_reg[i] <= '0;
            end
        end else begin
            in_frame_reg    <= in_frame_next;
            pos_reg         <= pos_next;
            running_xor_reg <= running_xor_next;
            for (int i = 0; i < 4; i++) begin
                recent_reg[i] <= recent_next[i];
            end
        end
    end

    `ASFX_ASSERT_IMP(a_pos_in_range, aclk, aresetn, in_frame_reg, (pos_reg >= 7'd1) && (pos_reg <= MAX_INDEX), "frame position out of range")
    `ASFX_ASSERT_NXT(a_emit_closes, aclk, aresetn, step && emit, !in_frame_reg, "frame still open after result")
    `ASFX_ASSERT_NXT(a_start_clears, aclk, aresetn, step && !in_frame_reg && (rx_byte == asfx_pkg::START_BYTE), in_frame_reg && (pos_reg == 7'd1) && (running_xor_reg == 8'd0), "frame start did not reset window")

endmodule

`default_nettype wire

// ----- hdl/asfx_out_reg.sv -----
`timescale 1ns / 1ps
`default_nettype none

module asfx_out_reg (
    input  wire logic                   aclk,
    input  wire logic                   aresetn,
    input  wire logic                   load,
    input  wire asfx_pkg::asfx_result_t load_data,
    output logic                        free,
    output logic                        valid,
    input  wire logic                   ready,
    output asfx_pkg::asfx_result_t      data
);

    logic                   valid_reg;
    asfx_pkg::asfx_result_t data_reg;

    // Slot is free when empty or drained this cycle.
    assign free  = !valid_reg || ready;
    assign valid = valid_reg;
    assign data  = data_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (load) begin
            valid_reg <= 1'b1;
        end else if (ready) begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            data_reg <= load_data;
        end
    end

endmodule

`default_nettype wire

// ----- hdl/ascii_sentence_framer_xor_check.sv -----
// Path: the input transaction is held in the input register, which feeds the result register behind m_valid.
// Throughput: one byte per cycle; a CR stalls only while an earlier result still waits in the
//   result register, since that register holds a single transaction.
// Reset (aresetn, synchronous, active low): empties both stages and returns the framer to
//   waiting for the '*' start byte with a cleared window.
`timescale 1ns / 1ps
`default_nettype none
`include "ascii_sentence_framer_xor_check_assert.svh"

module ascii_sentence_framer_xor_check #(
    parameter logic [asfx_pkg::POS_W-1:0] MAX_INDEX = asfx_pkg::MAX_INDEX
) (
    input  wire logic                        aclk,
    input  wire logic                        aresetn,
    input  wire logic                        s_valid,
    output logic                             s_ready,
    input  wire logic [asfx_pkg::BYTE_W-1:0] s_rx_byte,
    output logic                             m_valid,
    input  wire logic                        m_ready,
    output logic [asfx_pkg::POS_W-1:0]       m_frame_length,
    output logic [asfx_pkg::BYTE_W-1:0]      m_computed_xor,
    output logic [asfx_pkg::BYTE_W-1:0]      m_received_checksum,
    output logic                             m_hex_valid,
    output logic                             m_checksum_ok
);

    // Input stage: one byte waiting to be framed.
    logic                         in_valid_reg;
    logic [asfx_pkg::BYTE_W-1:0]  in_byte_reg;

    logic                         core_emit;
    logic                         core_step;
    logic                         out_free;
    asfx_pkg::asfx_result_t       core_result;
    asfx_pkg::asfx_result_t       out_data;

    // Advance the held byte unless it closes a frame and the result slot is occupied.
    assign core_step = in_valid_reg && (!core_emit || out_free);
    // Take a new byte whenever the input stage is empty or moves on this cycle.
    assign s_ready   = !in_valid_reg || core_step;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_valid && s_ready) begin
            in_valid_reg <= 1'b1;
        end else if (core_step) begin
            in_valid_reg <= 1'b0;
        end
    end

    // Payload only; no reset needed.
    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_byte_reg <= s_rx_byte;
        end
    end

    // Frame state, sliding window and checksum compare.
    asfx_frame_core #(
        .MAX_INDEX (MAX_INDEX)
    ) u_core (
        .aclk    (aclk),
        .aresetn (aresetn),
        .step    (core_step),
        .rx_byte (in_byte_reg),
        .emit    (core_emit),
        .result  (core_result)
    );

    // Result register; drop nothing, hold until the downstream takes it.
    asfx_out_reg u_out (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .load      (core_step && core_emit),
        .load_data (core_result),
        .free      (out_free),
        .valid     (m_valid),
        .ready     (m_ready),
        .data      (out_data)
    );

    assign m_frame_length      = out_data.frame_length;
    assign m_computed_xor      = out_data.computed_xor;
    assign m_received_checksum = out_data.received_checksum;
    assign m_hex_valid         = out_data.hex_valid;
    assign m_checksum_ok       = out_data.checksum_ok;

    `ASFX_ASSERT_NXT(a_blocked_byte_holds, aclk, aresetn, in_valid_reg && core_emit && !out_free, in_valid_reg && (in_byte_reg == $past(in_byte_reg)), "blocked CR left input stage")
    `ASFX_ASSERT_IMP(a_ok_needs_hex, aclk, aresetn, m_valid && m_checksum_ok, m_hex_valid && (m_frame_length >= asfx_pkg::MIN_CHECKED_LENGTH), "checksum_ok without valid hex or length")
    `ASFX_ASSERT_IMP(a_bad_hex_zero, aclk, aresetn, m_valid && !m_hex_valid, m_received_checksum == 8'd0, "nonzero checksum without hex digit")

endmodule

`default_nettype wire
